// File: rtl/hsv_to_rgb_pixel_converter_defines.svh
// Assertion macros used by the checker file of the HSV to RGB converter.
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define HSV2RGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define HSV2RGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // Field widths.
  localparam int unsigned HueW     = 16;
  localparam int unsigned UnitW    = 17;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  // Internal fixed-point widths: V*S in Q1.32, products in Q1.48, scaled by 255.
  localparam int unsigned VsW     = 33;
  localparam int unsigned Q48W    = 49;
  localparam int unsigned ScaledW = 56;

  // 1.0 in Q1.16.
  localparam logic [UnitW-1:0] OneQ16 = 17'h10000;

  // Queue between the front and the back.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Hue sectors, one sixth of a turn each.
  typedef enum logic [2:0] {
    SecRedToYellow   = 3'd0,
    SecYellowToGreen = 3'd1,
    SecGreenToCyan   = 3'd2,
    SecCyanToBlue    = 3'd3,
    SecBlueToMagenta = 3'd4,
    SecMagentaToRed  = 3'd5
  } sector_e;

  // A classified pixel as it travels from the front to the back.
  typedef struct packed {
    sector_e          sector;
    logic [UnitW-1:0] weight;
    logic [UnitW-1:0] sat;
    logic [UnitW-1:0] val;
  } item_t;

  // Limit a Q1.16 value to 1.0.
  function automatic logic [UnitW-1:0] clamp_unit(logic [UnitW-1:0] a);
    return (a > OneQ16) ? OneQ16 : a;
  endfunction

endpackage

// File: rtl/hsv_to_rgb_pixel_converter.sv
// HSV to RGB pixel converter. Takes one HSV word per clock and returns one
// 24-bit RGB word per clock for as long as the output side keeps taking words.
// A word accepted on the input passes through the classifying front register,
// the four-entry queue and the four-stage arithmetic pipeline (chroma multiply,
// secondary multiply, scaling by 255, sector select with offset add), whose
// last stage drives the output. Each channel is the exact floor of 255 times its
// value; saturation and brightness above 1.0 are taken as 1.0. When the output
// stalls, the block holds up to nine words (four in the pipeline, four in the
// queue and one in the front register) before the input drops tready.
module hsv_to_rgb_pixel_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // hue [15:0], saturation [32:16], brightness [49:33], zero fill [55:50]
  input  logic [hsv2rgb_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // red [7:0], green [15:8], blue [23:16]
  output logic [hsv2rgb_pkg::OutDataW-1:0]    m_axis_tdata_o
);

  logic                           fr_valid, fr_ready;
  hsv2rgb_pkg::item_t             fr_item;
  logic                           q_valid, q_ready;
  hsv2rgb_pkg::item_t             q_item;
  logic [hsv2rgb_pkg::ChanW-1:0]  red, green, blue;

  hsv2rgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .hue_i   (s_axis_tdata_i[15:0]),
    .sat_i   (s_axis_tdata_i[32:16]),
    .val_i   (s_axis_tdata_i[49:33]),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .item_o  (fr_item)
  );

  hsv2rgb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .item_i  (fr_item),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .item_o  (q_item)
  );

  hsv2rgb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .item_i  (q_item),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign m_axis_tdata_o = {blue, green, red};

endmodule

// File: rtl/hsv2rgb_front.sv
module hsv2rgb_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [hsv2rgb_pkg::HueW-1:0]     hue_i,
  input  logic [hsv2rgb_pkg::UnitW-1:0]    sat_i,
  input  logic [hsv2rgb_pkg::UnitW-1:0]    val_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output hsv2rgb_pkg::item_t               item_o
);

  logic                             vld_q, vld_d;
  hsv2rgb_pkg::item_t               item_q;
  hsv2rgb_pkg::item_t               item_d;
  logic [hsv2rgb_pkg::HueW+2:0]     six_h;
  logic [hsv2rgb_pkg::HueW-1:0]     frac;
  logic                             load;

  // The stage takes a new word when it is empty or its word leaves.
  assign ready_o = !vld_q || ready_i;
  assign load    = valid_i && ready_o;

  // Six times the hue: the top bits give the sector, the rest the fraction.
  always_comb begin
    six_h = ({3'b000, hue_i} << 2) + ({3'b000, hue_i} << 1);
    frac  = six_h[hsv2rgb_pkg::HueW-1:0];
    item_d.sector = hsv2rgb_pkg::sector_e'(six_h[hsv2rgb_pkg::HueW+2:hsv2rgb_pkg::HueW]);
    // Odd sectors ramp down, even sectors ramp up.
    if (six_h[hsv2rgb_pkg::HueW]) begin
      item_d.weight = hsv2rgb_pkg::OneQ16 - {1'b0, frac};
    end else begin
      item_d.weight = {1'b0, frac};
    end
    item_d.sat = hsv2rgb_pkg::clamp_unit(sat_i);
    item_d.val = hsv2rgb_pkg::clamp_unit(val_i);
  end

  always_comb begin
    vld_d = vld_q;
    if (ready_o) begin
      vld_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

// File: rtl/hsv2rgb_fifo.sv
module hsv2rgb_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  hsv2rgb_pkg::item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output hsv2rgb_pkg::item_t item_o
);

  hsv2rgb_pkg::item_t                   slot_q [hsv2rgb_pkg::FifoDepth];
  logic [hsv2rgb_pkg::FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [hsv2rgb_pkg::FifoPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [hsv2rgb_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic                                 push, pop;

  localparam logic [hsv2rgb_pkg::FifoPtrW-1:0] LastPtr =
    hsv2rgb_pkg::FifoPtrW'(hsv2rgb_pkg::FifoDepth - 1);
  localparam logic [hsv2rgb_pkg::FifoCntW-1:0] FullCnt =
    hsv2rgb_pkg::FifoCntW'(hsv2rgb_pkg::FifoDepth);

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign item_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/hsv2rgb_back.sv
module hsv2rgb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  hsv2rgb_pkg::item_t             item_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]  red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]  green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]  blue_o
);

  localparam int unsigned VsPad = hsv2rgb_pkg::VsW - hsv2rgb_pkg::UnitW;
  localparam int unsigned ScPad = hsv2rgb_pkg::ScaledW - hsv2rgb_pkg::Q48W;

  // Multiply by 255 as a shift and a subtract.
  function automatic logic [hsv2rgb_pkg::ScaledW-1:0] scale255(
    logic [hsv2rgb_pkg::Q48W-1:0] q
  );
    logic [hsv2rgb_pkg::ScaledW-1:0] wide;
    wide = {{ScPad{1'b0}}, q};
    return (wide << 8) - wide;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // Stage 1: chroma in Q1.32.
  hsv2rgb_pkg::sector_e              s1_sector_q;
  logic [hsv2rgb_pkg::UnitW-1:0]     s1_weight_q, s1_val_q;
  logic [hsv2rgb_pkg::VsW-1:0]       s1_vs_q;

  // Stage 2: chroma, secondary and offset in Q1.48.
  hsv2rgb_pkg::sector_e              s2_sector_q;
  logic [hsv2rgb_pkg::Q48W-1:0]      s2_c_q, s2_x_q, s2_m_q;

  // Stage 3: the same, scaled by 255.
  hsv2rgb_pkg::sector_e              s3_sector_q;
  logic [hsv2rgb_pkg::ScaledW-1:0]   s3_c_q, s3_x_q, s3_m_q;

  // Stage 4: output word.
  logic [hsv2rgb_pkg::ChanW-1:0]     red_q, green_q, blue_q;

  logic [hsv2rgb_pkg::ScaledW-1:0]   r_part, g_part, b_part;
  logic [hsv2rgb_pkg::ScaledW-1:0]   r_sum, g_sum, b_sum;

  // Each stage moves when it is empty or the stage after it moves.
  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      s1_sector_q <= item_i.sector;
      s1_weight_q <= item_i.weight;
      s1_val_q    <= item_i.val;
      s1_vs_q     <= {{VsPad{1'b0}}, item_i.val} * {{VsPad{1'b0}}, item_i.sat};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      s2_sector_q <= s1_sector_q;
      s2_c_q      <= {s1_vs_q, 16'h0000};
      s2_x_q      <= {16'h0000, s1_vs_q} * {32'h0000_0000, s1_weight_q};
      s2_m_q      <= {s1_val_q, 32'h0000_0000} - {s1_vs_q, 16'h0000};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      s3_sector_q <= s2_sector_q;
      s3_c_q      <= scale255(s2_c_q);
      s3_x_q      <= scale255(s2_x_q);
      s3_m_q      <= scale255(s2_m_q);
    end
  end

  // Place chroma and secondary on the channels of the sector.
  always_comb begin
    case (s3_sector_q)
      hsv2rgb_pkg::SecRedToYellow: begin
        r_part = s3_c_q; g_part = s3_x_q; b_part = '0;
      end
      hsv2rgb_pkg::SecYellowToGreen: begin
        r_part = s3_x_q; g_part = s3_c_q; b_part = '0;
      end
      hsv2rgb_pkg::SecGreenToCyan: begin
        r_part = '0; g_part = s3_c_q; b_part = s3_x_q;
      end
      hsv2rgb_pkg::SecCyanToBlue: begin
        r_part = '0; g_part = s3_x_q; b_part = s3_c_q;
      end
      hsv2rgb_pkg::SecBlueToMagenta: begin
        r_part = s3_x_q; g_part = '0; b_part = s3_c_q;
      end
      default: begin
        r_part = s3_c_q; g_part = '0; b_part = s3_x_q;
      end
    endcase
    r_sum = r_part + s3_m_q;
    g_sum = g_part + s3_m_q;
    b_sum = b_part + s3_m_q;
  end

  // The integer part of 255 times the channel value is the byte.
  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      red_q   <= r_sum[hsv2rgb_pkg::ScaledW-1:hsv2rgb_pkg::Q48W-1];
      green_q <= g_sum[hsv2rgb_pkg::ScaledW-1:hsv2rgb_pkg::Q48W-1];
      blue_q  <= b_sum[hsv2rgb_pkg::ScaledW-1:hsv2rgb_pkg::Q48W-1];
    end
  end

  assign valid_o = v4_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// File: rtl/hsv2rgb_chk.sv
`include "hsv_to_rgb_pixel_converter_defines.svh"

module hsv2rgb_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_tready_i,
  input logic                              m_tvalid_i,
  input logic                              m_tready_i,
  input logic [hsv2rgb_pkg::OutDataW-1:0]  m_tdata_i
);

  // A stalled output word stays offered.
  `HSV2RGB_ASSERT_NEXT(a_out_hold, m_tvalid_i && !m_tready_i, m_tvalid_i, "output word dropped")

  // A stalled output word keeps its value.
  `HSV2RGB_ASSERT_NEXT(a_out_stable, m_tvalid_i && !m_tready_i, $stable(m_tdata_i), "output word changed")

  // The input backs up only when the output holds a word.
  `HSV2RGB_ASSERT_NOW(a_backpressure_src, !s_tready_i, m_tvalid_i, "input stalled with empty output")

  // A full block stays full while the output is not drained.
  `HSV2RGB_ASSERT_NEXT(a_full_stays, !s_tready_i && !m_tready_i, !s_tready_i, "input freed without drain")

endmodule

bind hsv_to_rgb_pixel_converter hsv2rgb_chk u_hsv2rgb_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
